@@ hw/rtl/ncdf_pkg.sv @@
// constants for the normal cdf approximation: q.32 scaling, range reduction
// and polynomial coefficients. no dependencies
`default_nettype none

package ncdf_pkg;

  // fraction bits of the internal fixed-point format
  localparam int QF = 32;

  localparam logic [31:0] INV_SQRT2_Q = 32'd3037000500;
  localparam logic [31:0] LN2_Q       = 32'd2977044472;
  localparam logic [34:0] Z_LIMIT     = 35'd6 << 32;
  localparam logic [32:0] Q_ONE       = 33'd1 << 32;

  localparam longint unsigned P_Q =
    (64'd3275911 * 64'd4294967296 + 64'd5000000) / 64'd10000000;

  localparam longint unsigned A1_MAG =
    (64'd254829592 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A2_MAG =
    (64'd284496736 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A3_MAG =
    (64'd1421413741 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A4_MAG =
    (64'd1453152027 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A5_MAG =
    (64'd1061405429 * 64'd4294967296 + 64'd500000000) / 64'd1000000000;

  localparam logic signed [35:0] COEF_A1 = 36'(A1_MAG);
  localparam logic signed [35:0] COEF_A2 = 36'(64'd0 - A2_MAG);
  localparam logic signed [35:0] COEF_A3 = 36'(A3_MAG);
  localparam logic signed [35:0] COEF_A4 = 36'(64'd0 - A4_MAG);
  localparam logic signed [35:0] COEF_A5 = 36'(A5_MAG);

endpackage

`default_nettype wire

@@ hw/rtl/ncdf_mulq.sv @@
// two-stage q.32 multiplier: partial products, then sum with round half up
// depends on ncdf_pkg for the fraction width
`default_nettype none

module ncdf_mulq #(
  parameter int AW = 35,
  parameter int BW = 33,
  parameter int RW = 35
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [RW-1:0] p_o
);

  localparam int F   = ncdf_pkg::QF;
  localparam int AHW = AW - F;
  localparam int BHW = BW - F;
  localparam int PW  = AW + BW + 1;

  logic [2*F-1:0]     ll_q;
  logic [F+BHW-1:0]   lh_q;
  logic [AHW+F-1:0]   hl_q;
  logic [AHW+BHW-1:0] hh_q;
  logic [PW-1:0]      sum;

  always_ff @(posedge clk_i) begin
    ll_q <= (2*F)'(a_i[F-1:0]) * (2*F)'(b_i[F-1:0]);
    lh_q <= (F+BHW)'(a_i[F-1:0]) * (F+BHW)'(b_i[BW-1:F]);
    hl_q <= (AHW+F)'(a_i[AW-1:F]) * (AHW+F)'(b_i[F-1:0]);
    hh_q <= (AHW+BHW)'(a_i[AW-1:F]) * (AHW+BHW)'(b_i[BW-1:F]);
  end

  assign sum = PW'(ll_q) + (PW'(lh_q) << F) + (PW'(hl_q) << F)
             + (PW'(hh_q) << (2*F)) + (PW'(1) << (F-1));

  always_ff @(posedge clk_i) begin
    p_o <= sum[RW+F-1:F];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ncdf_delay.sv @@
// fixed-length shift line that carries side data alongside the pipeline
// no dependencies
`default_nettype none

module ncdf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

@@ hw/rtl/normal_cdf_approx.sv @@
// standard normal cdf, formula 7.1.26, as a 55-stage fixed-point pipeline
// depends on ncdf_pkg, ncdf_mulq and ncdf_delay
//
//   channel   ports                                direction  handshake
//   input     start_i, busy_o, sample_in_i         in         start_i && !busy_o
//   result    valid_o, probability_o               out        valid_o, one cycle
//
// one item is taken every cycle; busy_o stays low
// each result's timing is set by the exp series:
//   eleven horner steps, each a multiply, a divide by k and a subtract, after range reduction
// the reciprocal is a 17-stage restoring divider, two quotient bits a stage
// reset clears only the valid line; results cannot be held off
`default_nettype none

module normal_cdf_approx #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [19:0]       sample_in_i,
  output logic                     busy_o,
  output logic                     valid_o,
  output logic [OUT_FRAC_BITS:0]   probability_o
);

  localparam int LAT = 55;
  localparam int SH  = 33 - OUT_FRAC_BITS;

  assign busy_o = 1'b0;

  // valid line
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end
  assign valid_o = vld_q[LAT-1];

  // |x| / sqrt(2), clamped at 6
  logic [19:0] mag;
  logic [51:0] zr_q;
  logic [52:0] zr_rnd, zs;
  logic [34:0] z_q;

  assign mag = sample_in_i[19] ? (20'd0 - $unsigned(sample_in_i)) : $unsigned(sample_in_i);

  always_ff @(posedge clk_i) begin
    zr_q <= 52'(mag) * 52'(ncdf_pkg::INV_SQRT2_Q);
  end

  assign zr_rnd = 53'(zr_q) + (53'(1) << (IN_FRAC_BITS - 1));
  assign zs     = zr_rnd >> IN_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    z_q <= (zs > 53'(ncdf_pkg::Z_LIMIT)) ? ncdf_pkg::Z_LIMIT : zs[34:0];
  end

  // z*z and p*z
  logic [37:0] w;
  logic [32:0] pz;

  ncdf_mulq #(.AW(35), .BW(35), .RW(38)) u_mul_zz (
    .clk_i(clk_i), .a_i(z_q), .b_i(z_q), .p_o(w)
  );

  ncdf_mulq #(.AW(35), .BW(33), .RW(33)) u_mul_pz (
    .clk_i(clk_i), .a_i(z_q), .b_i(33'(ncdf_pkg::P_Q)), .p_o(pz)
  );

  // floor(2^65 / d), two quotient bits a stage
  logic [33:0] rd_r_q [17];
  logic [33:0] rd_q_q [17];
  logic [33:0] rd_d_q [17];

  for (genvar j = 0; j < 17; j++) begin : g_rdiv
    logic [33:0] r_in, q_in, d_in, r_a, r_b;
    logic [34:0] r2a, r2b;
    logic        ge_a, ge_b;

    if (j == 0) begin : g_first
      assign r_in = 34'd1 << 31;
      assign q_in = '0;
      assign d_in = (34'd1 << 32) + 34'(pz);
    end else begin : g_next
      assign r_in = rd_r_q[j-1];
      assign q_in = rd_q_q[j-1];
      assign d_in = rd_d_q[j-1];
    end

    always_comb begin
      r2a  = {r_in, 1'b0};
      ge_a = r2a >= 35'(d_in);
      r_a  = ge_a ? 34'(r2a - 35'(d_in)) : r2a[33:0];
      r2b  = {r_a, 1'b0};
      ge_b = r2b >= 35'(d_in);
      r_b  = ge_b ? 34'(r2b - 35'(d_in)) : r2b[33:0];
    end

    always_ff @(posedge clk_i) begin
      rd_r_q[j] <= r_b;
      rd_q_q[j] <= {q_in[31:0], ge_a, ge_b};
      rd_d_q[j] <= d_in;
    end
  end

  // t = round(2^64 / d)
  logic [34:0] tq_sum;
  logic [32:0] t_q;
  assign tq_sum = 35'(rd_q_q[16]) + 35'd1;
  always_ff @(posedge clk_i) begin
    t_q <= tq_sum[33:1];
  end

  // w = n*ln2 + r, six quotient bits over three stages
  logic [31:0] ed_r_q [3];
  logic [5:0]  ed_n_q [3];
  logic [5:0]  ed_w_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_ediv
    logic [31:0] r_in, r_a, r_b;
    logic [5:0]  n_in, wl_in;
    logic [32:0] r2a, r2b;
    logic        ge_a, ge_b;

    if (j == 0) begin : g_first
      assign r_in  = w[37:6];
      assign wl_in = w[5:0];
      assign n_in  = '0;
    end else begin : g_next
      assign r_in  = ed_r_q[j-1];
      assign wl_in = ed_w_q[j-1];
      assign n_in  = ed_n_q[j-1];
    end

    always_comb begin
      r2a  = {r_in, wl_in[5]};
      ge_a = r2a >= 33'(ncdf_pkg::LN2_Q);
      r_a  = ge_a ? 32'(r2a - 33'(ncdf_pkg::LN2_Q)) : r2a[31:0];
      r2b  = {r_a, wl_in[4]};
      ge_b = r2b >= 33'(ncdf_pkg::LN2_Q);
      r_b  = ge_b ? 32'(r2b - 33'(ncdf_pkg::LN2_Q)) : r2b[31:0];
    end

    always_ff @(posedge clk_i) begin
      ed_r_q[j] <= r_b;
      ed_n_q[j] <= {n_in[3:0], ge_a, ge_b};
      ed_w_q[j] <= {wl_in[3:0], 2'b00};
    end
  end

  // polynomial in t by horner, a multiply then a registered add per step
  logic [32:0]        pt [5];
  logic signed [35:0] po_s_q [4];

  assign pt[0] = t_q;

  for (genvar i = 0; i < 4; i++) begin : g_poly
    localparam logic signed [35:0] CF = (i == 0) ? ncdf_pkg::COEF_A4 :
                                        (i == 1) ? ncdf_pkg::COEF_A3 :
                                        (i == 2) ? ncdf_pkg::COEF_A2 : ncdf_pkg::COEF_A1;
    logic signed [35:0] s_in;
    logic [35:0]        s_abs;
    logic [34:0]        m;
    logic               sn;

    if (i == 0) begin : g_first
      assign s_in = ncdf_pkg::COEF_A5;
    end else begin : g_next
      assign s_in = po_s_q[i-1];
    end

    assign s_abs = s_in[35] ? (36'd0 - $unsigned(s_in)) : $unsigned(s_in);

    ncdf_delay #(.W(33), .DEPTH(3)) u_dly_t (
      .clk_i(clk_i), .d_i(pt[i]), .q_o(pt[i+1])
    );

    ncdf_delay #(.W(1), .DEPTH(2)) u_dly_sign (
      .clk_i(clk_i), .d_i(s_in[35]), .q_o(sn)
    );

    // magnitude product, sign put back afterwards: rounds half away from zero
    ncdf_mulq #(.AW(35), .BW(33), .RW(35)) u_mul (
      .clk_i(clk_i), .a_i(s_abs[34:0]), .b_i(pt[i]), .p_o(m)
    );

    always_ff @(posedge clk_i) begin
      po_s_q[i] <= (sn ? (36'd0 - 36'(m)) : 36'(m)) + CF;
    end
  end

  // t * P, with P clamped at zero
  logic [34:0] sc;
  logic [35:0] st, st_d;

  assign sc = po_s_q[3][35] ? '0 : po_s_q[3][34:0];

  ncdf_mulq #(.AW(35), .BW(33), .RW(36)) u_mul_st (
    .clk_i(clk_i), .a_i(sc), .b_i(pt[4]), .p_o(st)
  );

  ncdf_delay #(.W(36), .DEPTH(16)) u_dly_st (
    .clk_i(clk_i), .d_i(st), .q_o(st_d)
  );

  // exp(-r) by horner of the series: multiply, rounded divide by k, subtract from one
  logic [31:0] er [11];
  logic [32:0] ex_acc_q [11];
  logic [32:0] ex_u_q [11];
  logic [66:0] ex_p_q [11];

  assign er[0] = ed_r_q[2];

  for (genvar i = 0; i < 11; i++) begin : g_exp
    localparam int K = 11 - i;
    localparam logic [3:0]  KW = 4'(K);
    localparam logic [33:0] MK = 34'((64'd1 << 33) / K);
    logic [32:0] acc_in, u, qe, rem, q;
    logic [31:0] m;

    if (i == 0) begin : g_first
      assign acc_in = ncdf_pkg::Q_ONE;
    end else begin : g_next
      assign acc_in = ex_acc_q[i-1];
    end

    if (i < 10) begin : g_rline
      ncdf_delay #(.W(32), .DEPTH(4)) u_dly_r (
        .clk_i(clk_i), .d_i(er[i]), .q_o(er[i+1])
      );
    end

    ncdf_mulq #(.AW(33), .BW(33), .RW(32)) u_mul (
      .clk_i(clk_i), .a_i({1'b0, er[i]}), .b_i(acc_in), .p_o(m)
    );

    // rounded divide by k: reciprocal estimate is low by at most one
    assign u = 33'(m) + 33'(KW >> 1);

    always_ff @(posedge clk_i) begin
      ex_u_q[i] <= u;
      ex_p_q[i] <= 67'(u) * 67'(MK);
    end

    always_comb begin
      qe  = ex_p_q[i][65:33];
      rem = ex_u_q[i] - 33'(qe * KW);
      q   = (rem >= 33'(KW)) ? (qe + 33'd1) : qe;
    end

    always_ff @(posedge clk_i) begin
      ex_acc_q[i] <= ncdf_pkg::Q_ONE - q;
    end
  end

  // scale by 2^-n, round half up
  logic [5:0]  n_d;
  logic [32:0] acc_f, sh1, rb;
  logic [32:0] e_q;

  ncdf_delay #(.W(6), .DEPTH(44)) u_dly_n (
    .clk_i(clk_i), .d_i(ed_n_q[2]), .q_o(n_d)
  );

  assign acc_f = ex_acc_q[10];
  assign sh1   = acc_f >> n_d;
  assign rb    = acc_f >> (n_d - 6'd1);

  always_ff @(posedge clk_i) begin
    e_q <= (n_d == 6'd0) ? acc_f : (sh1 + 33'(rb[0]));
  end

  // term and output
  logic [35:0] term;
  logic        neg;
  logic [32:0] tc;
  logic [33:0] v33, vr;

  ncdf_mulq #(.AW(36), .BW(33), .RW(36)) u_mul_term (
    .clk_i(clk_i), .a_i(st_d), .b_i(e_q), .p_o(term)
  );

  ncdf_delay #(.W(1), .DEPTH(54)) u_dly_neg (
    .clk_i(clk_i), .d_i(sample_in_i[19]), .q_o(neg)
  );

  assign tc  = (term > 36'(ncdf_pkg::Q_ONE)) ? ncdf_pkg::Q_ONE : term[32:0];
  assign v33 = neg ? 34'(tc) : ((34'd1 << 33) - 34'(tc));
  assign vr  = v33 + (34'd1 << (SH - 1));

  always_ff @(posedge clk_i) begin
    probability_o <= vr[SH+OUT_FRAC_BITS:SH];
  end

  localparam logic [OUT_FRAC_BITS:0] HALF    = (OUT_FRAC_BITS+1)'(1) << (OUT_FRAC_BITS - 1);
  localparam logic [OUT_FRAC_BITS:0] ONE_OUT = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;

  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("result strobe without matching item");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> probability_o <= ONE_OUT)
    else $error("probability above one");

  a_neg_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(sample_in_i[19], LAT) |-> probability_o <= HALF)
    else $error("negative sample above one half");

  a_pos_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(sample_in_i[19], LAT) |-> probability_o >= HALF)
    else $error("non-negative sample below one half");

  a_zero_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ($past(sample_in_i, LAT) == 20'sd0) |-> probability_o == HALF)
    else $error("zero sample not one half");

endmodule

`default_nettype wire

@@ tb/sv/tb_normal_cdf_approx.sv @@
// self-checking testbench for normal_cdf_approx: directed table then random items
// predicts each probability not given in the table in q.32 fixed point; depends on ncdf_pkg
module tb_normal_cdf_approx;
  import ncdf_pkg::*;

  localparam int LATENCY = 55;

  typedef struct {
    logic signed [19:0] x;
    bit                 typed;
    logic [16:0]        prob;
  } cdf_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic signed [19:0] sample_in_i;
  logic               busy_o;
  logic               valid_o;
  logic [16:0]        probability_o;

  logic [16:0] prob_queue[$];
  int          mismatches;
  int          n_items;
  int          n_results;

  normal_cdf_approx dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .sample_in_i  (sample_in_i),
    .busy_o       (busy_o),
    .valid_o      (valid_o),
    .probability_o(probability_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // round(a*b / 2^32) half up, kept to 64 bits
  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
    return prod[95:32];
  endfunction

  function automatic longint q_smul(longint a, logic [63:0] b);
    logic [63:0] m;
    m = (a < 0) ? 64'(-a) : 64'(a);
    m = q_mul(m, b);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] exp_minus(logic [63:0] w);
    logic [63:0] n, r, acc, ln2;
    ln2 = {32'd0, LN2_Q};
    n   = q_mul(w, 64'd6196328019) >> 32;
    acc = {31'd0, Q_ONE};
    if (n > 0 && n * ln2 > w) n--;
    r = w - n * ln2;
    if (r >= ln2) begin
      r -= ln2;
      n++;
    end
    for (int k = 11; k >= 1; k--) begin
      acc = {31'd0, Q_ONE} - (q_mul(r, acc) + 64'(k / 2)) / 64'(k);
    end
    if (n == 0) return acc;
    if (n >= 63) return 64'd0;
    return (acc + (64'd1 << (n - 1))) >> n;
  endfunction

  // round(2^64 / d) half up
  function automatic logic [63:0] recip_q(logic [63:0] d);
    logic [127:0] num, q, rem;
    num = 128'd1 << 64;
    q   = num / {64'd0, d};
    rem = num - q * {64'd0, d};
    if (rem * 2 >= {64'd0, d}) q++;
    return q[63:0];
  endfunction

  function automatic logic [16:0] cdf_predict(logic signed [19:0] x);
    logic [20:0]  mag;
    logic [63:0]  z, w, e, t, term, v33;
    longint       s;
    longint       coef[5];
    coef[0] = longint'(COEF_A1);
    coef[1] = longint'(COEF_A2);
    coef[2] = longint'(COEF_A3);
    coef[3] = longint'(COEF_A4);
    coef[4] = longint'(COEF_A5);
    mag = x[19] ? (21'd1 << 20) - {1'b0, x} : {1'b0, x};
    z = ({43'd0, mag} * {32'd0, INV_SQRT2_Q} + 64'd32768) >> 16;
    if (z > {29'd0, Z_LIMIT}) z = {29'd0, Z_LIMIT};
    w = q_mul(z, z);
    e = exp_minus(w);
    t = recip_q({31'd0, Q_ONE} + q_mul(P_Q, z));
    s = coef[4];
    for (int i = 3; i >= 0; i--) s = q_smul(s, t) + coef[i];
    if (s < 0) s = 0;
    term = q_mul(q_mul(64'(s), t), e);
    if (term > {31'd0, Q_ONE}) term = {31'd0, Q_ONE};
    v33 = x[19] ? term : ({30'd0, Q_ONE, 1'b0} - term);
    return 17'((v33 + 64'd65536) >> 17);
  endfunction

  // one item, held until taken; may idle first unless quiet
  task automatic send_sample(logic signed [19:0] x, bit typed, logic [16:0] prob, bit quiet);
    bit was_busy;
    while (!quiet && $urandom_range(99) < 15) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    sample_in_i <= x;
    forever begin
      was_busy = busy_o;
      @(posedge clk_i);
      if (!was_busy) break;
      @(negedge clk_i);
    end
    prob_queue.push_back(typed ? prob : cdf_predict(x));
    n_items++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      n_results++;
      if (prob_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", probability_o);
      end else begin
        logic [16:0] want;
        want = prob_queue.pop_front();
        if (probability_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("probability mismatch: expected %0d got %0d", want, probability_o);
        end
      end
    end
  end

  initial begin
    #(8 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    cdf_row_t           rows[$];
    logic signed [19:0] x;
    int                 wait_cycles;
    mismatches  = 0;
    n_items     = 0;
    n_results   = 0;
    start_i     = 1'b0;
    sample_in_i = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero gives one half; saturation at both ends; the other rows are predicted
    rows.push_back('{20'sd0, 1'b1, 17'd32768});
    rows.push_back('{20'sd524287, 1'b1, 17'd65536});
    rows.push_back('{-20'sd524288, 1'b1, 17'd0});
    rows.push_back('{20'sd393216, 1'b1, 17'd65536});
    rows.push_back('{-20'sd393216, 1'b1, 17'd0});
    rows.push_back('{20'sd1, 1'b0, 17'd0});
    rows.push_back('{-20'sd1, 1'b0, 17'd0});
    rows.push_back('{20'sd65536, 1'b0, 17'd0});
    rows.push_back('{-20'sd65536, 1'b0, 17'd0});
    rows.push_back('{20'sd131072, 1'b0, 17'd0});
    rows.push_back('{-20'sd131072, 1'b0, 17'd0});
    rows.push_back('{20'sd32768, 1'b0, 17'd0});
    rows.push_back('{-20'sd32768, 1'b0, 17'd0});
    rows.push_back('{20'sd262144, 1'b0, 17'd0});
    rows.push_back('{-20'sd262144, 1'b0, 17'd0});
    rows.push_back('{20'sd45426, 1'b0, 17'd0});
    rows.push_back('{20'sd327680, 1'b0, 17'd0});
    rows.push_back('{-20'sd327680, 1'b0, 17'd0});
    rows.push_back('{20'sd555000 - 20'sd555000 + 20'sd370000, 1'b0, 17'd0});
    rows.push_back('{20'h55555, 1'b0, 17'd0});
    rows.push_back('{20'hAAAAA, 1'b0, 17'd0});
    foreach (rows[i]) send_sample(rows[i].x, rows[i].typed, rows[i].prob, 1'b0);

    for (int i = 0; i < 1850; i++) begin
      case ($urandom_range(9))
        0, 1:    x = 20'($urandom);
        2, 3, 4: x = 20'($signed($urandom_range(2 * 262144)) - 262144);
        5, 6:    x = 20'($signed($urandom_range(2 * 65536)) - 65536);
        7:       x = 20'($signed($urandom_range(64)) - 32);
        default: x = $urandom_range(1) ? 20'($urandom_range(524287, 380000))
                                       : -20'($urandom_range(524288, 380000));
      endcase
      send_sample(x, 1'b0, 17'd0, i >= 600 && i < 900);
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (prob_queue.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (prob_queue.size() != 0) mismatches += prob_queue.size();

    $display("sent %0d samples across the full signed range, %0d probabilities checked",
             n_items, n_results);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
